@@ rtl/rpf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpf_pkg
// Shared constants, codes and types for the record predicate filter.
// ----------------------------------------------------------------------------
package rpf_pkg;

  localparam int KEY_BYTES        = 256;
  localparam int MAX_RECORD_BYTES = 4096;
  localparam int KEY_AW           = $clog2(KEY_BYTES);
  localparam int POS_W            = $clog2(MAX_RECORD_BYTES);
  localparam int LEN_W            = POS_W + 1;
  localparam int CFG_W            = 32;
  localparam int CFG_IDX_W        = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_W-1:0]     cfg_data_t;

  // register indexes
  localparam cfg_idx_t REG_ATTR_TYPE   = 3'd0;
  localparam cfg_idx_t REG_COMPARE_OP  = 3'd1;
  localparam cfg_idx_t REG_ATTR_OFFSET = 3'd2;
  localparam cfg_idx_t REG_ATTR_LENGTH = 3'd3;
  localparam cfg_idx_t REG_MATCH_ANY   = 3'd4;
  localparam cfg_idx_t REG_INT_CONST   = 3'd5;
  localparam cfg_idx_t REG_FLOAT_CONST = 3'd6;

  // attribute types
  localparam logic [1:0] TYPE_INT    = 2'd0;
  localparam logic [1:0] TYPE_FLOAT  = 2'd1;
  localparam logic [1:0] TYPE_STRING = 2'd2;

  // compare ops
  localparam logic [3:0] OP_EQ     = 4'd1;
  localparam logic [3:0] OP_LT     = 4'd2;
  localparam logic [3:0] OP_GT     = 4'd3;
  localparam logic [3:0] OP_LE     = 4'd4;
  localparam logic [3:0] OP_GE     = 4'd5;
  localparam logic [3:0] OP_NE     = 4'd6;
  localparam logic [3:0] OP_ALWAYS = 4'd7;

  // order codes
  typedef enum logic [1:0] {
    ORD_EQ = 2'd0,
    ORD_LT = 2'd1,
    ORD_GT = 2'd2
  } ord_t;

  localparam logic CMD_KEY = 1'b0;

  function automatic logic apply_op(logic [3:0] op, ord_t ord);
    logic m;
    m = 1'b0;
    case (op)
      OP_EQ:   m = (ord == ORD_EQ);
      OP_LT:   m = (ord == ORD_LT);
      OP_GT:   m = (ord == ORD_GT);
      OP_LE:   m = (ord != ORD_GT);
      OP_GE:   m = (ord != ORD_LT);
      OP_NE:   m = (ord != ORD_EQ);
      default: m = 1'b0;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/rpf_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpf_in_if / rpf_out_if
// Valid/ready channels for record and key beats and for per-record results.
// ----------------------------------------------------------------------------
interface rpf_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] key_index;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, cmd, key_index, data_byte, last, input ready);
  modport sink   (input valid, cmd, key_index, data_byte, last, output ready);
endinterface

interface rpf_out_if;
  logic valid;
  logic ready;
  logic match;
  logic short_record;

  modport source (output valid, match, short_record, input ready);
  modport sink   (input valid, match, short_record, output ready);
endinterface

@@ rtl/record_predicate_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_predicate_filter
// Scan predicate over records streamed one byte per beat.
// ----------------------------------------------------------------------------
// Usage:
//  in_ch carries beats: cmd=0 loads data_byte into key byte key_index,
//  cmd=1 is one record byte, last marks the final byte of a record.
//  out_ch carries one result beat per record (match, short_record).
//  cfg_we/cfg_index/cfg_wdata write the predicate registers; write only
//  while the block is idle.
//  Throughput: one beat per cycle unless in_ch ready drops on an out_ch stall.
//  A record's result shows on out_ch after its last byte is accepted and
//  passes the input stage (with key RAM read), then the judge into the
//  result register.
//  The key RAM (256 x 8, one write and one registered read port) sets the
//  split into two stages: the string compare uses the registered key byte.
//  Reset (synchronous, rst_n low) restores register defaults and clears
//  record state; the key RAM is not cleared and must be loaded before use.
//  When out_ch stalls with a result waiting, the pipeline holds and in_ch
//  ready drops once a further last byte reaches stage 1; no beat is lost.
// ----------------------------------------------------------------------------
module record_predicate_filter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  rpf_pkg::cfg_idx_t   cfg_index,
  input  rpf_pkg::cfg_data_t  cfg_wdata,
  rpf_in_if.sink              in_ch,
  rpf_out_if.source           out_ch
);
  import rpf_pkg::*;

  // configuration registers
  logic [1:0]  attr_type_r;
  logic [3:0]  compare_op_r;
  logic [8:0]  attr_offset_r;
  logic [8:0]  attr_length_r;
  logic        match_any_r;
  logic [31:0] int_const_r;
  logic [31:0] float_const_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_type_r   <= TYPE_INT;
      compare_op_r  <= OP_ALWAYS;
      attr_offset_r <= '0;
      attr_length_r <= 9'd4;
      match_any_r   <= 1'b1;
      int_const_r   <= '0;
      float_const_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ATTR_TYPE:   attr_type_r   <= cfg_wdata[1:0];
        REG_COMPARE_OP:  compare_op_r  <= cfg_wdata[3:0];
        REG_ATTR_OFFSET: attr_offset_r <= cfg_wdata[8:0];
        REG_ATTR_LENGTH: attr_length_r <= cfg_wdata[8:0];
        REG_MATCH_ANY:   match_any_r   <= cfg_wdata[0];
        REG_INT_CONST:   int_const_r   <= cfg_wdata;
        REG_FLOAT_CONST: float_const_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // key store
  logic [7:0] key_mem [KEY_BYTES];
  logic [7:0] key_q_r;

  // record state (input stage)
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             ovf_r, ovf_nxt;
  logic [31:0]      word_r, word_nxt;

  // stage 1 registers
  logic        s1_valid_r;
  logic        s1_last_r;
  logic        s1_str_r;
  logic [7:0]  s1_byte_r;
  logic [31:0] s1_word_r;
  logic        s1_short_r;

  // stage 2 state and result register
  ord_t ord_r, ord_nxt;
  logic out_valid_r, out_match_r, out_short_r;

  logic adv, accept, rec_beat;
  assign adv      = !s1_valid_r || !s1_last_r || !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign accept   = in_ch.valid && adv;
  assign rec_beat = accept && (in_ch.cmd != CMD_KEY);

  // span and capture window
  logic [8:0]       span;
  logic [POS_W-1:0] k;
  logic             in_span;
  logic [POS_W-1:0] pos_inc;
  logic [LEN_W-1:0] len_new;
  logic [LEN_W-1:0] attr_end;
  logic             short_new;

  always_comb begin
    if (attr_type_r != TYPE_STRING) span = 9'd4;
    else if (attr_length_r > 9'(KEY_BYTES)) span = 9'(KEY_BYTES);
    else span = attr_length_r;
    k       = pos_r - POS_W'(attr_offset_r);
    in_span = !ovf_r && (pos_r >= POS_W'(attr_offset_r)) && (k < POS_W'(span));
    pos_inc = pos_r + 1'b1;

    pos_nxt  = pos_r;
    ovf_nxt  = ovf_r;
    word_nxt = word_r;
    if (!ovf_r) begin
      if (pos_r == POS_W'(MAX_RECORD_BYTES - 1)) ovf_nxt = 1'b1;
      else pos_nxt = pos_inc;
      if (in_span && attr_type_r != TYPE_STRING)
        word_nxt = word_r | (32'(in_ch.data_byte) << {k[1:0], 3'b000});
    end
    len_new   = ovf_nxt ? LEN_W'(MAX_RECORD_BYTES) : LEN_W'(pos_nxt);
    attr_end  = LEN_W'(attr_offset_r) + LEN_W'(span);
    short_new = len_new < attr_end;
  end

  always_ff @(posedge clk) begin
    if (accept && in_ch.cmd == CMD_KEY)
      key_mem[in_ch.key_index] <= in_ch.data_byte;
    if (rec_beat)
      key_q_r <= key_mem[k[KEY_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      ovf_r      <= 1'b0;
      word_r     <= '0;
      s1_valid_r <= 1'b0;
      s1_last_r  <= 1'b0;
      s1_str_r   <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= rec_beat;
      if (rec_beat) begin
        s1_last_r  <= in_ch.last;
        s1_str_r   <= in_span && attr_type_r == TYPE_STRING;
        s1_byte_r  <= in_ch.data_byte;
        s1_word_r  <= word_nxt;
        s1_short_r <= short_new;
        if (in_ch.last) begin
          pos_r  <= '0;
          ovf_r  <= 1'b0;
          word_r <= '0;
        end else begin
          pos_r  <= pos_nxt;
          ovf_r  <= ovf_nxt;
          word_r <= word_nxt;
        end
      end
    end
  end

  // judge stage
  logic signed [32:0] fa, fb;
  logic               nan_a, nan_b;
  ord_t               ord_int, ord_flt;
  logic               m, sh;

  always_comb begin
    ord_nxt = ord_r;
    if (s1_str_r && ord_r == ORD_EQ) begin
      if ($signed(s1_byte_r) < $signed(key_q_r)) ord_nxt = ORD_LT;
      else if ($signed(s1_byte_r) > $signed(key_q_r)) ord_nxt = ORD_GT;
    end

    if ($signed(s1_word_r) < $signed(int_const_r)) ord_int = ORD_LT;
    else if ($signed(s1_word_r) > $signed(int_const_r)) ord_int = ORD_GT;
    else ord_int = ORD_EQ;

    fa = s1_word_r[31] ? -$signed({2'b00, s1_word_r[30:0]})
                       : $signed({2'b00, s1_word_r[30:0]});
    fb = float_const_r[31] ? -$signed({2'b00, float_const_r[30:0]})
                           : $signed({2'b00, float_const_r[30:0]});
    if (fa < fb) ord_flt = ORD_LT;
    else if (fa > fb) ord_flt = ORD_GT;
    else ord_flt = ORD_EQ;
    nan_a = (s1_word_r[30:23] == 8'hFF) && (s1_word_r[22:0] != '0);
    nan_b = (float_const_r[30:23] == 8'hFF) && (float_const_r[22:0] != '0);

    m  = 1'b0;
    sh = 1'b0;
    if (match_any_r || compare_op_r == OP_ALWAYS) begin
      m = 1'b1;
    end else if (compare_op_r >= OP_EQ && compare_op_r <= OP_NE
                 && attr_type_r <= TYPE_STRING) begin
      if (s1_short_r) sh = 1'b1;
      else if (attr_type_r == TYPE_INT) m = apply_op(compare_op_r, ord_int);
      else if (attr_type_r == TYPE_FLOAT) begin
        if (nan_a || nan_b) m = (compare_op_r == OP_NE);
        else m = apply_op(compare_op_r, ord_flt);
      end else m = apply_op(compare_op_r, ord_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ord_r       <= ORD_EQ;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.ready) out_valid_r <= 1'b0;
      if (s1_valid_r && adv) begin
        ord_r <= s1_last_r ? ORD_EQ : ord_nxt;
        if (s1_last_r) begin
          out_valid_r <= 1'b1;
          out_match_r <= m;
          out_short_r <= sh;
        end
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.match        = out_match_r;
  assign out_ch.short_record = out_short_r;

endmodule

@@ test/tb_record_predicate_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_record_predicate_filter
// Self-checking bench for the record predicate filter: a directed table of
// beats, directed register cases, then random records and key loads over
// many register settings, each result beat checked by a behavioral predictor.
// ----------------------------------------------------------------------------
module tb_record_predicate_filter;
  import rpf_pkg::*;

  localparam logic [3:0] OP_NEVER = 4'd8;
  localparam int LIMIT_CYCLES = 2000000;

  typedef struct packed {
    logic       cmd;
    logic [7:0] key_index;
    logic [7:0] data_byte;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic match;
    logic short_record;
  } verdict_t;

  // directed table row: a beat, plus an optional typed-in verdict
  typedef struct packed {
    beat_t    b;
    logic     has_exp;
    verdict_t exp;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_index;
  cfg_data_t cfg_wdata;

  rpf_in_if  in_ch ();
  rpf_out_if out_ch ();

  record_predicate_filter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  // predictor copy of registers and record state
  logic [1:0]  p_type;
  logic [3:0]  p_op;
  logic [8:0]  p_offset;
  logic [8:0]  p_length;
  logic        p_any;
  logic [31:0] p_int;
  logic [31:0] p_flt;
  logic [7:0]  p_keys [KEY_BYTES];
  int unsigned p_pos;
  ord_t        p_order;
  logic [31:0] p_word;
  logic        p_ovf;

  verdict_t verdict_q[$];
  int errors;
  int cycles;
  bit stall_hold;  // receiver long hold-off
  bit hold_go;     // starts the hold-off while short records stream
  bit no_idle;     // stretch with no idling on either side

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int unsigned attr_span();
    if (p_type != TYPE_STRING) return 4;
    return (p_length > KEY_BYTES) ? KEY_BYTES : p_length;
  endfunction

  function automatic bit is_nan(logic [31:0] v);
    return (v[30:23] == 8'hFF) && (v[22:0] != 0);
  endfunction

  // sign-magnitude ordering key; +0 and -0 both map to zero
  function automatic longint flt_key(logic [31:0] v);
    longint mag;
    mag = longint'(v[30:0]);
    return v[31] ? -mag : mag;
  endfunction

  function automatic ord_t order_of(longint a, longint c);
    if (a < c) return ORD_LT;
    if (a > c) return ORD_GT;
    return ORD_EQ;
  endfunction

  function automatic bit op_holds(ord_t o);
    case (p_op)
      OP_EQ:   return o == ORD_EQ;
      OP_LT:   return o == ORD_LT;
      OP_GT:   return o == ORD_GT;
      OP_LE:   return o != ORD_GT;
      OP_GE:   return o != ORD_LT;
      OP_NE:   return o != ORD_EQ;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void cfg_model(cfg_idx_t idx, cfg_data_t v);
    case (idx)
      REG_ATTR_TYPE:   p_type = v[1:0];
      REG_COMPARE_OP:  p_op = v[3:0];
      REG_ATTR_OFFSET: p_offset = v[8:0];
      REG_ATTR_LENGTH: p_length = v[8:0];
      REG_MATCH_ANY:   p_any = v[0];
      REG_INT_CONST:   p_int = v;
      REG_FLOAT_CONST: p_flt = v;
      default: ;
    endcase
  endfunction

  // advance the predictor by one accepted beat; queue any verdict
  function automatic void filter_step(beat_t b);
    int unsigned k;
    int unsigned len;
    verdict_t v;
    if (b.cmd == CMD_KEY) begin
      p_keys[b.key_index] = b.data_byte;
      return;
    end
    if (!p_ovf) begin
      if (p_pos >= p_offset && p_pos - p_offset < attr_span()) begin
        k = p_pos - p_offset;
        if (p_type == TYPE_STRING) begin
          if (p_order == ORD_EQ)
            p_order = order_of(longint'($signed(b.data_byte)),
                               longint'($signed(p_keys[k[7:0]])));
        end else begin
          p_word = p_word | (32'(b.data_byte) << (8 * (k % 4)));
        end
      end
      if (p_pos + 1 >= MAX_RECORD_BYTES) p_ovf = 1'b1;
      else p_pos++;
    end
    if (!b.last) return;
    len = p_ovf ? MAX_RECORD_BYTES : p_pos;
    v = '0;
    if (p_any || p_op == OP_ALWAYS) begin
      v.match = 1'b1;
    end else if (p_op >= OP_EQ && p_op <= OP_NE && p_type <= TYPE_STRING) begin
      if (len < p_offset + attr_span()) v.short_record = 1'b1;
      else if (p_type == TYPE_INT)
        v.match = op_holds(order_of(longint'($signed(p_word)),
                                    longint'($signed(p_int))));
      else if (p_type == TYPE_FLOAT) begin
        if (is_nan(p_word) || is_nan(p_flt)) v.match = (p_op == OP_NE);
        else v.match = op_holds(order_of(flt_key(p_word), flt_key(p_flt)));
      end else
        v.match = op_holds(p_order);
    end
    verdict_q.push_back(v);
    p_pos = 0;
    p_order = ORD_EQ;
    p_word = '0;
    p_ovf = 1'b0;
  endfunction

  // result side: random stalls, a long hold-off, compare against the queue
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result beat match=%b short=%b", $time,
                   out_ch.match, out_ch.short_record);
          errors++;
        end else begin
          if (out_ch.match !== verdict_q[0].match) begin
            $display("%0t: match expected %b actual %b", $time,
                     verdict_q[0].match, out_ch.match);
            errors++;
          end
          if (out_ch.short_record !== verdict_q[0].short_record) begin
            $display("%0t: short_record expected %b actual %b", $time,
                     verdict_q[0].short_record, out_ch.short_record);
            errors++;
          end
          void'(verdict_q.pop_front());
        end
      end
      out_ch.ready <= !stall_hold && (no_idle || $urandom_range(99) >= 10);
    end
  end

  // long receiver hold-off, counted here; short records keep coming meanwhile
  initial begin
    stall_hold = 1'b0;
    wait (hold_go);
    stall_hold = 1'b1;
    repeat (400) @(posedge clk);
    stall_hold = 1'b0;
  end

  task automatic send_beat(beat_t b);
    // optional idle cycles before offering
    while (!no_idle && $urandom_range(99) < 10) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= b.cmd;
    in_ch.key_index <= b.key_index;
    in_ch.data_byte <= b.data_byte;
    in_ch.last <= b.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    filter_step(b);
  endtask

  // drain and wait out pipeline latency before reprogramming
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_model(idx, v);
  endtask

  function automatic beat_t rec_byte(logic [7:0] d, logic l);
    beat_t b;
    b.cmd = 1'b1;
    b.key_index = 8'($urandom);
    b.data_byte = d;
    b.last = l;
    return b;
  endfunction

  task automatic send_record(int n, logic [31:0] word, bit use_word);
    for (int i = 0; i < n; i++) begin
      logic [7:0] d;
      d = 8'($urandom);
      if (use_word && i >= p_offset && i - p_offset < 4)
        d = word[8 * (i - p_offset) +: 8];
      else if (p_type == TYPE_STRING && i >= p_offset && i - p_offset < attr_span()
               && $urandom_range(3) != 0)
        d = p_keys[(i - p_offset) % KEY_BYTES]; // mostly equal prefixes
      send_beat(rec_byte(d, i == n - 1));
    end
  endtask

  function automatic logic [31:0] pick_float();
    case ($urandom_range(6))
      0: return 32'h7FC0_0001;   // NaN
      1: return 32'h8000_0000;   // -0
      2: return 32'h0000_0000;
      3: return 32'h7F80_0000;   // +inf
      4: return 32'hFF80_0000;
      default: return $urandom;
    endcase
  endfunction

  row_t dir_rows[$];

  initial begin
    row_t r;
    int n_items;
    errors = 0;
    cycles = 0;
    no_idle = 1'b0;
    hold_go = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = 1'b0;
    in_ch.key_index = '0;
    in_ch.data_byte = '0;
    in_ch.last = 1'b0;
    p_type = TYPE_INT; p_op = OP_ALWAYS; p_offset = 0; p_length = 4;
    p_any = 1'b1; p_int = '0; p_flt = '0;
    p_pos = 0; p_order = ORD_EQ; p_word = '0; p_ovf = 1'b0;
    foreach (p_keys[i]) p_keys[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: after reset every record matches, single-byte record too.
    dir_rows.push_back('{rec_byte(8'hFF, 1'b1), 1'b1, '{1'b1, 1'b0}});
    dir_rows.push_back('{rec_byte(8'h00, 1'b0), 1'b0, '0});
    dir_rows.push_back('{rec_byte(8'h80, 1'b1), 1'b1, '{1'b1, 1'b0}});
    // key loads at both ends of the store
    dir_rows.push_back('{beat_t'{1'b0, 8'd0, 8'h7F, 1'b1}, 1'b0, '0});
    dir_rows.push_back('{beat_t'{1'b0, 8'd255, 8'h80, 1'b0}, 1'b0, '0});
    dir_rows.push_back('{beat_t'{1'b0, 8'd1, 8'h80, 1'b0}, 1'b0, '0});
    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      send_beat(r.b);
      if (r.has_exp && verdict_q[$] !== r.exp) begin
        $display("%0t: table row %0d expected %b actual %b", $time, i, r.exp,
                 verdict_q[$]);
        errors++;
      end
    end
    drain();
    // load the whole key store so string compares never read unwritten bytes
    for (int i = 0; i < KEY_BYTES; i++)
      send_beat(beat_t'{1'b0, 8'(i), 8'($urandom), 1'b0});
    drain();

    // Directed: integer extremes, short record, never op, unknown op and type.
    write_reg(REG_MATCH_ANY, 0);
    write_reg(REG_COMPARE_OP, OP_EQ);
    write_reg(REG_INT_CONST, 32'h8000_0000);
    send_record(4, 32'h8000_0000, 1);   // eq at minimum
    send_record(3, 0, 0);               // short record
    drain();
    write_reg(REG_INT_CONST, 32'h7FFF_FFFF);
    write_reg(REG_COMPARE_OP, OP_LT);
    send_record(5, 32'h8000_0000, 1);
    drain();
    write_reg(REG_COMPARE_OP, OP_NEVER);
    send_record(4, 0, 0);
    drain();
    write_reg(REG_COMPARE_OP, 4'd15);   // unknown op
    send_record(4, 0, 0);
    drain();
    write_reg(REG_COMPARE_OP, OP_GE);
    write_reg(REG_ATTR_TYPE, 3);        // unknown type
    send_record(4, 0, 0);
    drain();
    // long record past the position limit
    write_reg(REG_ATTR_TYPE, TYPE_STRING);
    write_reg(REG_ATTR_OFFSET, 264);
    write_reg(REG_ATTR_LENGTH, 256);
    send_record(MAX_RECORD_BYTES + 3, 0, 0);
    send_record(300, 0, 0);             // short string
    drain();

    // Random part: phases with different settings.
    n_items = 0;
    for (int ph = 0; n_items < 1700; ph++) begin
      int recs;
      drain();
      write_reg(REG_ATTR_TYPE, (ph % 9 == 8) ? 3 : ph % 3);
      write_reg(REG_COMPARE_OP, (ph % 7 == 6) ? $urandom_range(15) : $urandom_range(1, 6));
      write_reg(REG_ATTR_OFFSET, (ph % 5 == 0) ? 0 : $urandom_range(0, 12));
      write_reg(REG_ATTR_LENGTH, (ph % 6 == 0) ? $urandom_range(256, 511)
                                               : $urandom_range(0, 8));
      write_reg(REG_MATCH_ANY, (ph % 10 == 9));
      write_reg(REG_INT_CONST, (ph % 4 == 0) ? 32'h7FFF_FFFF : $urandom);
      write_reg(REG_FLOAT_CONST, pick_float());
      no_idle = (ph == 4);
      if (ph == 2) hold_go = 1'b1;
      recs = 0;
      while (recs < 12) begin
        int len;
        logic [31:0] w;
        // occasional key reload mid-phase, between records
        if ($urandom_range(9) == 0) begin
          send_beat(beat_t'{1'b0, 8'($urandom), 8'($urandom), 1'($urandom)});
          n_items++;
        end
        len = (p_length > 16 && p_type == TYPE_STRING && $urandom_range(3) == 0)
              ? $urandom_range(250, 280) : $urandom_range(1, 20);
        w = (p_type == TYPE_FLOAT) ? pick_float()
          : ($urandom_range(2) == 0 ? p_int : $urandom);
        if (p_type == TYPE_FLOAT && $urandom_range(3) == 0) w = p_flt;
        send_record(len, w, p_type != TYPE_STRING);
        n_items += len;
        recs++;
      end
    end

    drain();
    in_ch.valid <= 1'b0;
    repeat (20) @(posedge clk);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("status: pass");
    end else begin
      if (verdict_q.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, verdict_q.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/rpf_pkg.sv
rtl/rpf_if.sv
rtl/record_predicate_filter.sv
test/tb_record_predicate_filter.sv
